FILE: rtl/wel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wel_pkg: shared types for the worker load tracker
// payload structs, divider control and fixed constants
// ----------------------------------------------------------------------------
package wel_pkg;

    localparam int unsigned LaneDivisor = 85;
    localparam int unsigned Lanes       = 3;
    localparam int unsigned MicroPerSec = 1000000;
    localparam logic [16:0] OneQ16      = 17'd65536;
    localparam logic [16:0] WeightReset = 17'd13107;
    localparam logic [0:0]  RegWeight   = 1'b0;
    localparam logic        ActDispatch = 1'b0;

    typedef struct packed {
        logic        action;
        logic [5:0]  worker_index;
        logic [7:0]  priority_req;
        logic [31:0] service_lat;
        logic [31:0] byte_count;
    } wel_in_t;

    typedef struct packed {
        logic [31:0] sample_count;
        logic [15:0] inflight_count;
        logic [43:0] service_avg;
        logic [27:0] queue_avg;
        logic [51:0] throughput_avg;
        logic [1:0]  lane_index;
        logic [31:0] lane_count;
    } wel_out_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/worker_ewma_load_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worker_ewma_load_tracker_core: per-worker load telemetry
// ewma tracking of service time, queue depth and throughput per worker
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// s_       | in        | s_valid / s_ready  | wel_in_t event
// m_       | out       | m_valid / m_ready  | wel_out_t statistics
// apb      | in        | psel/penable/pready| ewma_weight where paddr[2] = 0
//
// a dispatch runs only the queue-depth blend step before m_valid rises; a completion
// runs two 64-step restoring divider passes (quotient, then fraction bits) and all
// five steps of the shared 32x17 blend multiplier
// reset sweeps all WORKERS rows of the worker table clear before s_ready rises
// the result sits in an output register; s_ready stays low until it is taken
// ----------------------------------------------------------------------------
module worker_ewma_load_tracker_core #(
    parameter int unsigned WORKERS       = 64,
    parameter int unsigned FRACTION_BITS = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wel_pkg::wel_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output wel_pkg::wel_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import wel_pkg::*;

    localparam int unsigned AW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int unsigned RW = 32 + 16 + 44 + 28 + 64;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_DIV, S_FRAC, S_BLEND, S_WRITE, S_OUT
    } state_t;

    // blend step selects: which average goes through the multiplier
    typedef enum logic [2:0] {
        B_QLO, B_SLO, B_SHI, B_TLO, B_THI
    } bstep_t;

    state_t      state_reg;
    bstep_t      bstep_reg;
    logic [1:0]  phase_reg;
    logic [16:0] weight_reg;
    logic [AW-1:0] wk_reg;
    logic [AW-1:0] clr_reg;
    wel_in_t     in_reg;
    wel_out_t    out_reg;
    logic        m_valid_reg;
    logic [1:0]  lane_reg;
    logic [31:0] lane_d_reg [Lanes];
    logic [31:0] lane_c_reg [Lanes];

    // stored entry fields
    logic [31:0] smp_reg;
    logic [15:0] inf_reg;
    logic [43:0] svc_reg;
    logic [27:0] que_reg;
    logic [63:0] thr_reg;
    logic [63:0] tv_reg;
    logic [63:0] q_reg;
    logic        first_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;

    // worker table ram, one row per worker
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    wel_ram #(.WIDTH(RW), .DEPTH(WORKERS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (wk_reg),
        .rdata (ram_rdata)
    );

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : wk_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : {smp_reg, inf_reg, svc_reg, que_reg, thr_reg};

    // count fields of the row just read
    logic [31:0] rd_smp;
    logic [15:0] rd_inf;
    assign rd_smp = ram_rdata[RW-1 -: 32];
    assign rd_inf = ram_rdata[RW-33 -: 16];

    // shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic [31:0] svc_val;
    logic [63:0] bytes_scaled;

    assign svc_val      = (in_reg.service_lat == 32'd0) ? 32'd1 : in_reg.service_lat;
    assign bytes_scaled = 64'(in_reg.byte_count) * 64'(MicroPerSec);

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = bytes_scaled;
        div_req.divisor  = svc_val;
        if (state_reg == S_READ && phase_reg == 2'd1 && in_reg.action != ActDispatch) begin
            div_req.start = 1'b1;
        end else if (state_reg == S_DIV && div_rsp.done) begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(div_rsp.remainder) << FRACTION_BITS;
        end
    end

    wel_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // shared blend multiplier: one 32x17 product per cycle
    logic [16:0] w_eff;
    logic [16:0] v_eff;
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;
    logic [63:0] qv_new;
    logic [63:0] sv_new;
    logic [63:0] x_sel;
    logic [63:0] o_sel;
    logic        hi_sel;

    assign w_eff  = (weight_reg > OneQ16) ? OneQ16 : weight_reg;
    assign v_eff  = OneQ16 - w_eff;
    assign qv_new = 64'(inf_reg) << FRACTION_BITS;
    assign sv_new = 64'(svc_val) << FRACTION_BITS;

    always_comb begin
        x_sel  = qv_new;
        o_sel  = 64'(que_reg);
        hi_sel = 1'b0;
        unique case (bstep_reg)
            B_QLO: begin
                x_sel = qv_new; o_sel = 64'(que_reg);
            end
            B_SLO: begin
                x_sel = sv_new; o_sel = 64'(svc_reg);
            end
            B_SHI: begin
                x_sel = sv_new; o_sel = 64'(svc_reg); hi_sel = 1'b1;
            end
            B_TLO: begin
                x_sel = tv_reg; o_sel = thr_reg;
            end
            B_THI: begin
                x_sel = tv_reg; o_sel = thr_reg; hi_sel = 1'b1;
            end
            default: ;
        endcase
        mul_a = (phase_reg[0] == 1'b0) ? (hi_sel ? x_sel[63:32] : x_sel[31:0])
                                       : (hi_sel ? o_sel[63:32] : o_sel[31:0]);
        mul_b = (phase_reg[0] == 1'b0) ? w_eff : v_eff;
    end

    assign mul_p = 49'(mul_a) * 49'(mul_b);

    logic [63:0] blend_res;
    // lo sum lives in acc_reg after lo steps; hi sum in prod_reg
    assign blend_res = (prod_reg << 16) + (acc_reg >> 16);

    logic [31:0] lane_cnt;
    assign lane_cnt = (in_reg.action == ActDispatch) ? lane_d_reg[lane_reg]
                                                     : lane_c_reg[lane_reg];

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            weight_reg  <= WeightReset;
            m_valid_reg <= 1'b0;
            phase_reg   <= '0;
            bstep_reg   <= B_QLO;
            for (int i = 0; i < Lanes; i++) begin
                lane_d_reg[i] <= '0;
                lane_c_reg[i] <= '0;
            end
        end else begin
            if (psel && penable && pwrite && paddr[2] == RegWeight) begin
                weight_reg <= pwdata[16:0];
            end
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == WORKERS - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        in_reg    <= s_data;
                        wk_reg    <= AW'(32'(s_data.worker_index) % WORKERS);
                        lane_reg  <= (s_data.priority_req >= 8'(2 * LaneDivisor)) ? 2'd2 :
                                     (s_data.priority_req >= 8'(LaneDivisor)) ? 2'd1 : 2'd0;
                        phase_reg <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    // phase 0 waits for the registered ram read; phase 1 uses it
                    if (phase_reg == 2'd1) begin
                        svc_reg   <= ram_rdata[RW-49 -: 44];
                        que_reg   <= ram_rdata[RW-93 -: 28];
                        thr_reg   <= ram_rdata[63:0];
                        first_reg <= (rd_smp == 32'd0);
                        phase_reg <= '0;
                        if (in_reg.action == ActDispatch) begin
                            smp_reg <= rd_smp;
                            inf_reg <= (rd_inf != 16'hFFFF) ? rd_inf + 16'd1 : rd_inf;
                            if (lane_d_reg[lane_reg] != 32'hFFFF_FFFF) begin
                                lane_d_reg[lane_reg] <= lane_d_reg[lane_reg] + 32'd1;
                            end
                            bstep_reg <= B_QLO;
                            state_reg <= S_BLEND;
                        end else begin
                            smp_reg <= (rd_smp != 32'hFFFF_FFFF) ? rd_smp + 32'd1 : rd_smp;
                            inf_reg <= (rd_inf != 16'd0) ? rd_inf - 16'd1 : rd_inf;
                            if (lane_c_reg[lane_reg] != 32'hFFFF_FFFF) begin
                                lane_c_reg[lane_reg] <= lane_c_reg[lane_reg] + 32'd1;
                            end
                            state_reg <= S_DIV;
                        end
                    end else begin
                        phase_reg <= 2'd1;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        q_reg     <= div_rsp.quotient;
                        state_reg <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    if (div_rsp.done) begin
                        if (in_reg.byte_count == 32'd0) begin
                            tv_reg <= '0;
                        end else if ((q_reg >> (64 - FRACTION_BITS)) != 64'd0) begin
                            tv_reg <= '1;
                        end else begin
                            tv_reg <= (q_reg << FRACTION_BITS) + div_rsp.quotient;
                        end
                        bstep_reg <= B_QLO;
                        phase_reg <= '0;
                        state_reg <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    // phases: 0 new term, 1 old term, 2 commit
                    if (phase_reg == 2'd0) begin
                        if (hi_sel) begin
                            prod_reg <= 64'(mul_p);
                        end else begin
                            acc_reg <= 64'(mul_p) + 64'd32768;
                        end
                        phase_reg <= 2'd1;
                    end else if (phase_reg == 2'd1) begin
                        if (hi_sel) begin
                            prod_reg <= prod_reg + 64'(mul_p);
                        end else begin
                            acc_reg <= acc_reg + 64'(mul_p);
                        end
                        phase_reg <= 2'd2;
                    end else begin
                        phase_reg <= 2'd0;
                        case (bstep_reg)
                            B_QLO: begin
                                que_reg <= first_reg ? 28'(qv_new) : 28'(acc_reg >> 16);
                                if (in_reg.action == ActDispatch) begin
                                    state_reg <= S_WRITE;
                                end else begin
                                    bstep_reg <= B_SLO;
                                end
                            end
                            B_SLO: bstep_reg <= B_SHI;
                            B_SHI: begin
                                svc_reg   <= first_reg ? 44'(sv_new) : 44'(blend_res);
                                bstep_reg <= B_TLO;
                            end
                            B_TLO: bstep_reg <= B_THI;
                            B_THI: begin
                                thr_reg   <= first_reg ? tv_reg : blend_res;
                                state_reg <= S_WRITE;
                            end
                            default: state_reg <= S_WRITE;
                        endcase
                    end
                end
                S_WRITE: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    out_reg.sample_count   <= smp_reg;
                    out_reg.inflight_count <= inf_reg;
                    out_reg.service_avg    <= svc_reg;
                    out_reg.queue_avg      <= que_reg;
                    out_reg.throughput_avg <= 52'(thr_reg >> FRACTION_BITS);
                    out_reg.lane_index     <= lane_reg;
                    out_reg.lane_count     <= lane_cnt;
                    m_valid_reg            <= 1'b1;
                    state_reg              <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == RegWeight) ? 32'(weight_reg) : 32'd0;
endmodule

FILE: rtl/wel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wel_ram: generic simple dual-port ram
// one write port, one registered read port
// ----------------------------------------------------------------------------
module wel_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/wel_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wel_div: radix-2 restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wel_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  wel_pkg::div_req_t req,
    output wel_pkg::div_rsp_t rsp
);
    import wel_pkg::*;

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], quo_reg[63]} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                // shift in one dividend bit, subtract if it fits
                if (!trial[32]) begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[31:0], quo_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[31:0];
endmodule

FILE: rtl/wel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wel_checker: port-level checks for the load tracker
// ordering of transactions, lane range and payload stability
// ----------------------------------------------------------------------------
module wel_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input wel_pkg::wel_out_t m_data
);
    // one event at a time: no input while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    // an accepted event drops ready next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready after accept");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped while stalled");

    a_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.lane_index != 2'd3)) else $error("bad lane");
endmodule

bind worker_ewma_load_tracker_core wel_checker u_wel_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/sv/tb_worker_ewma_load_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worker_ewma_load_tracker_core: self-checking bench for the load tracker
// dispatch and completion events go in through a queue-fed driver; a local
// model of the per-worker ewma tables predicts every statistics transaction,
// and a monitor checks each one field by field under random backpressure
// ----------------------------------------------------------------------------
module tb_worker_ewma_load_tracker_core;
    import wel_pkg::*;

    localparam int unsigned NumWorkers = 64;
    localparam int unsigned FracBits   = 12;
    localparam int unsigned WatchLimit = 20000;
    localparam int unsigned PressCycles = 1500;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    wel_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    wel_out_t          m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    worker_ewma_load_tracker_core #(
        .WORKERS      (NumWorkers),
        .FRACTION_BITS(FracBits)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // local copy of the tracker state
    // ------------------------------------------------------------------
    logic [16:0] weight_q16;
    logic [31:0] samples   [NumWorkers];
    logic [15:0] inflight  [NumWorkers];
    logic [63:0] svc_avg   [NumWorkers];
    logic [63:0] depth_avg [NumWorkers];
    logic [63:0] rate_avg  [NumWorkers];
    logic [31:0] lane_disp [3];
    logic [31:0] lane_done [3];

    wel_in_t  event_queue[$];   // events not yet offered
    wel_out_t stats_queue[$];   // predicted statistics, oldest first

    int unsigned mismatches = 0;
    bit          idle_on;
    bit          press_go;
    bit          s_fire;
    int unsigned s_gap;
    int unsigned m_gap;
    int unsigned press_cnt;
    bit          press_done;
    int unsigned quiet_cycles;
    bit          apb_fire;

    // rounded blend of a new value into an average
    function automatic logic [63:0] ewma_mix(logic [63:0] x, logic [63:0] old);
        logic [127:0] w;
        logic [127:0] acc;
        w   = (weight_q16 > OneQ16) ? 128'(OneQ16) : 128'(weight_q16);
        acc = w * x + (128'd65536 - w) * old + 128'd32768;
        return acc[79:16];
    endfunction

    // bytes per second with FracBits fraction bits, zero when nothing moved
    function automatic logic [63:0] rate_value(logic [31:0] bytes, logic [31:0] svc);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] frac;
        if (bytes == 0)
            return 64'd0;
        num  = 128'(bytes) * 128'(MicroPerSec);
        q    = num / svc;
        r    = num % svc;
        if (q > (128'hFFFF_FFFF_FFFF_FFFF >> FracBits))
            return 64'hFFFF_FFFF_FFFF_FFFF;
        frac = (r << FracBits) / svc;
        return 64'((q << FracBits) + frac);
    endfunction

    // applies one event to the local tables and returns the expected statistics
    function automatic wel_out_t track_event(wel_in_t ev);
        wel_out_t    res;
        int unsigned wk;
        int unsigned lane;
        bit          first;
        logic [31:0] svc;
        logic [63:0] qv;
        logic [63:0] tv;
        wk    = ev.worker_index % NumWorkers;
        lane  = ev.priority_req / LaneDivisor;
        if (lane > Lanes - 1)
            lane = Lanes - 1;
        first = (samples[wk] == 0);
        if (ev.action == ActDispatch) begin
            if (inflight[wk] != 16'hFFFF)
                inflight[wk]++;
            qv = 64'(inflight[wk]) << FracBits;
            depth_avg[wk] = first ? qv : ewma_mix(qv, depth_avg[wk]);
            if (lane_disp[lane] != 32'hFFFF_FFFF)
                lane_disp[lane]++;
            res.lane_count = lane_disp[lane];
        end else begin
            svc = (ev.service_lat == 0) ? 32'd1 : ev.service_lat;
            tv  = rate_value(ev.byte_count, svc);
            if (samples[wk] != 32'hFFFF_FFFF)
                samples[wk]++;
            if (inflight[wk] != 0)
                inflight[wk]--;
            qv = 64'(inflight[wk]) << FracBits;
            if (first) begin
                svc_avg[wk]   = 64'(svc) << FracBits;
                depth_avg[wk] = qv;
                rate_avg[wk]  = tv;
            end else begin
                svc_avg[wk]   = ewma_mix(64'(svc) << FracBits, svc_avg[wk]);
                depth_avg[wk] = ewma_mix(qv, depth_avg[wk]);
                rate_avg[wk]  = ewma_mix(tv, rate_avg[wk]);
            end
            if (lane_done[lane] != 32'hFFFF_FFFF)
                lane_done[lane]++;
            res.lane_count = lane_done[lane];
        end
        res.sample_count   = samples[wk];
        res.inflight_count = inflight[wk];
        res.service_avg    = svc_avg[wk][43:0];
        res.queue_avg      = depth_avg[wk][27:0];
        res.throughput_avg = 52'(rate_avg[wk] >> FracBits);
        res.lane_index     = 2'(lane);
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 200);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued events, inputs move on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else if (!s_valid || s_fire) begin
            if (s_gap != 0) begin
                s_gap   <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (event_queue.size() != 0) begin
                s_data  <= event_queue.pop_front();
                s_valid <= 1'b1;
                s_gap   <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with random stalls and one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            m_gap      <= 0;
            press_cnt  <= 0;
            press_done <= 1'b0;
        end else if (press_go && !press_done && press_cnt == 0) begin
            press_cnt  <= PressCycles;
            press_done <= 1'b1;
            m_ready    <= 1'b0;
        end else if (press_cnt != 0) begin
            press_cnt <= press_cnt - 1;
            m_ready   <= (press_cnt == 1);
        end else if (m_gap != 0) begin
            m_gap   <= m_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            m_gap   <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on input acceptance, checks on output acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        wel_out_t want;
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            stats_queue.insert(stats_queue.size(), track_event(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (stats_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected statistics transaction %h", m_data);
            end else begin
                want = stats_queue.pop_front();
                if (m_data.sample_count   !== want.sample_count   ||
                    m_data.inflight_count !== want.inflight_count ||
                    m_data.service_avg    !== want.service_avg    ||
                    m_data.queue_avg      !== want.queue_avg      ||
                    m_data.throughput_avg !== want.throughput_avg ||
                    m_data.lane_index     !== want.lane_index     ||
                    m_data.lane_count     !== want.lane_count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: statistics mismatch at %0t", $realtime);
                        $display("  samples  exp %0d got %0d",
                                 want.sample_count, m_data.sample_count);
                        $display("  inflight exp %0d got %0d",
                                 want.inflight_count, m_data.inflight_count);
                        $display("  service  exp %h got %h",
                                 want.service_avg, m_data.service_avg);
                        $display("  queue    exp %h got %h",
                                 want.queue_avg, m_data.queue_avg);
                        $display("  rate     exp %h got %h",
                                 want.throughput_avg, m_data.throughput_avg);
                        $display("  lane     exp %0d/%0d got %0d/%0d",
                                 want.lane_index, want.lane_count,
                                 m_data.lane_index, m_data.lane_count);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no transaction on any port
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || apb_fire || !aresetn)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WatchLimit) begin
            $display("Regression FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // apb write: setup then access phase, both set up on the falling edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        apb_fire = 1'b1;
        @(negedge aclk);
        apb_fire = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // weight change, only while nothing is in flight
    task automatic set_weight(input logic [16:0] w);
        apb_write({RegWeight, 2'b00}, 32'(w));
        weight_q16 = w;
    endtask

    // waits for the queue and the block to drain
    task automatic drain();
        wait (event_queue.size() == 0 && !s_valid && stats_queue.size() == 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic add_event(input logic act, input logic [5:0] wk, input logic [7:0] pr,
                             input logic [31:0] lat, input logic [31:0] bytes);
        wel_in_t ev;
        ev.action       = act;
        ev.worker_index = wk;
        ev.priority_req = pr;
        ev.service_lat  = lat;
        ev.byte_count   = bytes;
        event_queue.insert(event_queue.size(), ev);
    endtask

    // random events: a few hot workers keep real dispatch/complete histories
    task automatic add_random(input int unsigned n);
        logic [31:0] lat;
        logic [31:0] bytes;
        logic [5:0]  wk;
        logic [7:0]  pr;
        repeat (n) begin
            wk = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       pr = 8'($urandom_range(84, 86));
                1:       pr = 8'($urandom_range(169, 171));
                default: pr = 8'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       lat = 32'd0;
                1:       lat = $urandom;
                2:       lat = 32'hFFFF_FFFF;
                default: lat = $urandom_range(1, 50000);
            endcase
            case ($urandom_range(0, 7))
                0:       bytes = 32'd0;
                1, 2:    bytes = $urandom;
                3:       bytes = 32'hFFFF_FFFF;
                default: bytes = $urandom_range(1, 1 << 20);
            endcase
            add_event(1'($urandom_range(0, 1)), wk, pr, lat, bytes);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial begin
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        apb_fire   = 1'b0;
        idle_on    = 1'b1;
        press_go   = 1'b0;
        weight_q16 = WeightReset;
        for (int i = 0; i < NumWorkers; i++) begin
            samples[i]   = '0;
            inflight[i]  = '0;
            svc_avg[i]   = '0;
            depth_avg[i] = '0;
            rate_avg[i]  = '0;
        end
        for (int i = 0; i < 3; i++) begin
            lane_disp[i] = '0;
            lane_done[i] = '0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: default weight, fresh workers take raw values
        add_event(ActDispatch, 6'd0, 8'd0, 32'd0, 32'd0);
        add_event(ActDispatch, 6'd0, 8'd84, 32'd5, 32'd7);
        add_event(~ActDispatch, 6'd0, 8'd85, 32'd100, 32'd4096);
        add_event(ActDispatch, 6'd0, 8'd169, 32'd0, 32'd0);
        add_event(~ActDispatch, 6'd0, 8'd170, 32'd250, 32'd1);
        add_event(~ActDispatch, 6'd0, 8'd255, 32'd3, 32'd0);
        add_event(~ActDispatch, 6'd0, 8'd255, 32'd3, 32'd0);   // in-flight floor
        add_event(~ActDispatch, 6'd63, 8'd255, 32'd0, 32'hFFFF_FFFF); // zero latency
        add_event(~ActDispatch, 6'd63, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_event(~ActDispatch, 6'd62, 8'd1, 32'hFFFF_FFFF, 32'd1);
        add_event(ActDispatch, 6'd63, 8'd86, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_event(~ActDispatch, 6'd42, 8'd170, 32'h5555_5555, 32'hAAAA_AAAA);
        add_event(~ActDispatch, 6'd21, 8'd85, 32'hAAAA_AAAA, 32'h5555_5555);
        add_event(ActDispatch, 6'd21, 8'd128, 32'd1, 32'd1);
        add_event(~ActDispatch, 6'd21, 8'd200, 32'd1, 32'd1000);
        add_event(~ActDispatch, 6'd1, 8'd10, 32'd0, 32'd0);   // nothing moved
        add_event(~ActDispatch, 6'd1, 8'd10, 32'd7, 32'd0);
        drain();

        // nothing but random traffic from here on
        add_random(360);
        drain();

        set_weight(17'd1);
        add_random(180);
        drain();

        set_weight(OneQ16);        // raw values replace averages
        idle_on = 1'b0;            // back-to-back traffic
        add_random(160);
        drain();

        set_weight(17'd0);         // averages frozen after the first sample
        idle_on = 1'b1;
        add_random(120);
        drain();

        set_weight(17'h1FFFF);     // above one acts as one
        add_random(100);
        drain();

        // long receiver hold-off while events keep coming
        set_weight(17'($urandom_range(1, 65535)));
        press_go = 1'b1;
        add_random(160);
        drain();

        if (mismatches == 0 && stats_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
